// ----- src/ctfp_pkg.sv -----
`default_nettype none

package ctfp_pkg;

    // Width of one text character and of the frame fields.
    localparam int CHAR_W        = 8;
    localparam int ID_W          = 12;
    localparam int LEN_W         = 4;
    localparam int PAYLOAD_BYTES = 8;
    localparam int PAYLOAD_W     = 8 * PAYLOAD_BYTES;
    localparam int NIBBLE_W      = 4;

    // Characters with a meaning of their own in the frame text.
    localparam logic [CHAR_W-1:0] CH_HASH     = 8'h23;
    localparam logic [CHAR_W-1:0] CH_DOT      = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_REMOTE_U = 8'h52;
    localparam logic [CHAR_W-1:0] CH_REMOTE_L = 8'h72;

    // Largest length a remote request may ask for.
    localparam logic [NIBBLE_W:0] REMOTE_MAX_LEN = 5'd8;

    // Where the parser stands within the frame text.
    typedef enum logic [2:0] {
        PH_ID,
        PH_HASH,
        PH_AFTER_HASH,
        PH_DATA_HI,
        PH_DATA_LO,
        PH_RLEN,
        PH_IGNORE
    } t_phase;

    // One parsed frame as it leaves the block.
    typedef struct packed {
        logic                 frame_ok;
        logic [ID_W-1:0]      can_id;
        logic                 remote_request;
        logic [LEN_W-1:0]     data_length;
        logic [PAYLOAD_W-1:0] payload;
    } t_frame;

endpackage

`default_nettype wire

// ----- src/ctfp_if.sv -----
`default_nettype none

// Character channel: one text character per word.
interface ctfp_char_if;
    logic                           valid;
    logic                           ready;
    logic [ctfp_pkg::CHAR_W-1:0]    character;
    logic                           last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

// Frame channel: one parsed frame per word.
interface ctfp_frame_if;
    logic                           valid;
    logic                           ready;
    logic                           frame_ok;
    logic [ctfp_pkg::ID_W-1:0]      can_id;
    logic                           remote_request;
    logic [ctfp_pkg::LEN_W-1:0]     data_length;
    logic [ctfp_pkg::PAYLOAD_W-1:0] payload;

    modport source (output valid, output frame_ok, output can_id, output remote_request,
                    output data_length, output payload, input ready);
    modport sink   (input valid, input frame_ok, input can_id, input remote_request,
                    input data_length, input payload, output ready);
endinterface

`default_nettype wire

// ----- src/can_text_frame_parser_core.sv -----
`default_nettype none

// Channel   Direction  Word                                  Handshake
// i_char    in         character[7:0], last_char             valid / ready
// o_frame   out        frame_ok, can_id[11:0],               valid / ready
//                      remote_request, data_length[3:0],
//                      payload[63:0]
//
// One character is taken in every cycle; the parse state advances in the same
// cycle and a frame is ready in the output register the cycle after its last
// character. While the output register is empty, or its frame leaves in the
// same cycle, characters flow back to back. While a frame is held and the
// downstream side is not ready, every character stalls. Reset is synchronous,
// active low, and returns the parser to the first identifier digit.

module can_text_frame_parser_core #(
    parameter int MAX_DATA_BYTES = 8
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    ctfp_char_if.sink     i_char,
    ctfp_frame_if.source  o_frame
);

    // Accepted character, handed to the parser in the same cycle.
    logic             in_ready;
    logic             accept;

    // A frame completes on the last character of the text.
    logic             res_valid;
    ctfp_pkg::t_frame res;

    // Frame held for the downstream side.
    logic             out_valid;
    ctfp_pkg::t_frame out_frame;

    assign accept       = i_char.valid && in_ready;
    assign i_char.ready = in_ready;

    // The parser holds the position, identifier, payload bytes, pending nibble
    // and error flag, and builds the frame from the state left by the last
    // character.
    ctfp_parser #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_character  (i_char.character),
        .i_last_char  (i_char.last_char),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // The output register takes a frame whenever it is empty or emptying.
    ctfp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (res_valid),
        .i_frame     (res),
        .i_ready     (o_frame.ready),
        .o_valid     (out_valid),
        .o_frame     (out_frame),
        .o_in_ready  (in_ready)
    );

    assign o_frame.valid          = out_valid;
    assign o_frame.frame_ok       = out_frame.frame_ok;
    assign o_frame.can_id         = out_frame.can_id;
    assign o_frame.remote_request = out_frame.remote_request;
    assign o_frame.data_length    = out_frame.data_length;
    assign o_frame.payload        = out_frame.payload;

endmodule

`default_nettype wire

// ----- src/ctfp_parser.sv -----
`default_nettype none

module ctfp_parser #(
    parameter int MAX_DATA_BYTES = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire logic [ctfp_pkg::CHAR_W-1:0] i_character,
    input  wire logic                        i_last_char,
    output logic                             o_res_valid,
    output ctfp_pkg::t_frame                 o_res
);

    // Hex digit value; the top bit set means the character is not a hex digit.
    function automatic logic [ctfp_pkg::NIBBLE_W:0] hex_value(
        input logic [ctfp_pkg::CHAR_W-1:0] ch
    );
        logic [ctfp_pkg::NIBBLE_W:0] v;
        v = 5'h10;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            v = 5'(ch - 8'h30);
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            v = 5'(ch - 8'h37);
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            v = 5'(ch - 8'h57);
        end
        return v;
    endfunction

    localparam logic [ctfp_pkg::LEN_W-1:0] MAX_BYTES = ctfp_pkg::LEN_W'(MAX_DATA_BYTES);

    ctfp_pkg::t_phase                  r_phase, n_phase;
    logic [1:0]                        r_pos, n_pos;
    logic [ctfp_pkg::ID_W-1:0]         r_id, n_id;
    logic [ctfp_pkg::PAYLOAD_W-1:0]    r_data, n_data;
    logic [ctfp_pkg::LEN_W-1:0]        r_bytes, n_bytes;
    logic [ctfp_pkg::NIBBLE_W-1:0]     r_nib, n_nib;
    logic                              r_dot, n_dot;
    logic                              r_err, n_err;
    logic                              r_remote, n_remote;
    logic [ctfp_pkg::LEN_W-1:0]        r_rlen, n_rlen;

    logic [ctfp_pkg::NIBBLE_W:0]       v;
    logic                              bad;
    logic                              take_high;
    logic [ctfp_pkg::LEN_W-1:0]        bytes_inc;
    logic [7:0]                        data_byte;
    logic                              ok;

    assign v         = hex_value(i_character);
    assign bad       = v[ctfp_pkg::NIBBLE_W];
    assign bytes_inc = r_bytes + 4'd1;
    assign data_byte = {r_nib, v[ctfp_pkg::NIBBLE_W-1:0]};

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_id      = r_id;
        n_data    = r_data;
        n_bytes   = r_bytes;
        n_nib     = r_nib;
        n_dot     = r_dot;
        n_err     = r_err;
        n_remote  = r_remote;
        n_rlen    = r_rlen;
        take_high = 1'b0;
        ok        = 1'b0;
        o_res     = '0;

        if (i_accept && !r_err) begin
            case (r_phase)
                ctfp_pkg::PH_ID: begin
                    if (bad) begin
                        n_err = 1'b1;
                    end else begin
                        n_id  = {r_id[ctfp_pkg::ID_W-5:0], v[ctfp_pkg::NIBBLE_W-1:0]};
                        n_pos = r_pos + 2'd1;
                        if (r_pos == 2'd2) begin
                            n_phase = ctfp_pkg::PH_HASH;
                        end
                    end
                end
                ctfp_pkg::PH_HASH: begin
                    if (i_character == ctfp_pkg::CH_HASH) begin
                        n_phase = ctfp_pkg::PH_AFTER_HASH;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                ctfp_pkg::PH_AFTER_HASH: begin
                    if (i_character == ctfp_pkg::CH_REMOTE_U ||
                        i_character == ctfp_pkg::CH_REMOTE_L) begin
                        n_remote = 1'b1;
                        n_phase  = ctfp_pkg::PH_RLEN;
                    end else begin
                        take_high = 1'b1;
                    end
                end
                ctfp_pkg::PH_DATA_HI: begin
                    take_high = 1'b1;
                end
                ctfp_pkg::PH_DATA_LO: begin
                    if (bad) begin
                        n_err = 1'b1;
                    end else begin
                        for (int i = 0; i < ctfp_pkg::PAYLOAD_BYTES; i++) begin
                            if (r_bytes[2:0] == 3'(i)) begin
                                n_data[8*i +: 8] = data_byte;
                            end
                        end
                        n_bytes = bytes_inc;
                        n_nib   = '0;
                        n_dot   = 1'b0;
                        n_phase = (bytes_inc >= MAX_BYTES) ? ctfp_pkg::PH_IGNORE
                                                           : ctfp_pkg::PH_DATA_HI;
                    end
                end
                ctfp_pkg::PH_RLEN: begin
                    if (v <= ctfp_pkg::REMOTE_MAX_LEN) begin
                        n_rlen = v[ctfp_pkg::NIBBLE_W-1:0];
                    end
                    n_phase = ctfp_pkg::PH_IGNORE;
                end
                default: begin
                end
            endcase

            // First digit of a data byte, or the single dot that may precede it.
            if (take_high) begin
                if (i_character == ctfp_pkg::CH_DOT && !r_dot) begin
                    n_dot   = 1'b1;
                    n_phase = ctfp_pkg::PH_DATA_HI;
                end else if (bad) begin
                    n_err = 1'b1;
                end else begin
                    n_nib   = v[ctfp_pkg::NIBBLE_W-1:0];
                    n_phase = ctfp_pkg::PH_DATA_LO;
                end
            end
        end

        // The last character closes the frame and returns the parser to its start.
        if (i_accept && i_last_char) begin
            ok = !n_err && !(n_phase inside {ctfp_pkg::PH_ID, ctfp_pkg::PH_HASH,
                                             ctfp_pkg::PH_DATA_LO});
            if (ok) begin
                o_res.frame_ok       = 1'b1;
                o_res.can_id         = n_id;
                o_res.remote_request = n_remote;
                o_res.data_length    = n_remote ? n_rlen : n_bytes;
                o_res.payload        = n_remote ? '0 : n_data;
            end
            n_phase  = ctfp_pkg::PH_ID;
            n_pos    = '0;
            n_id     = '0;
            n_data   = '0;
            n_bytes  = '0;
            n_nib    = '0;
            n_dot    = 1'b0;
            n_err    = 1'b0;
            n_remote = 1'b0;
            n_rlen   = '0;
        end
    end

    assign o_res_valid = i_accept && i_last_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= ctfp_pkg::PH_ID;
            r_pos    <= '0;
            r_id     <= '0;
            r_data   <= '0;
            r_bytes  <= '0;
            r_nib    <= '0;
            r_dot    <= 1'b0;
            r_err    <= 1'b0;
            r_remote <= 1'b0;
            r_rlen   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_id     <= n_id;
            r_data   <= n_data;
            r_bytes  <= n_bytes;
            r_nib    <= n_nib;
            r_dot    <= n_dot;
            r_err    <= n_err;
            r_remote <= n_remote;
            r_rlen   <= n_rlen;
        end
    end

    a_restart_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_phase == ctfp_pkg::PH_ID && r_bytes == '0 && !r_err))
        else $error("parser did not restart after a frame");

    a_byte_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes <= MAX_BYTES)
        else $error("byte count beyond the allowed data bytes");

    a_error_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.frame_ok) |->
            (o_res.can_id == '0 && !o_res.remote_request &&
             o_res.data_length == '0 && o_res.payload == '0))
        else $error("failed frame carries nonzero fields");

    a_remote_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.remote_request) |-> (o_res.payload == '0))
        else $error("remote frame carries payload");

endmodule

`default_nettype wire

// ----- src/ctfp_out_reg.sv -----
`default_nettype none

module ctfp_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire ctfp_pkg::t_frame  i_frame,
    input  wire logic              i_ready,
    output logic                   o_valid,
    output ctfp_pkg::t_frame       o_frame,
    output logic                   o_in_ready
);

    logic             r_valid, n_valid;
    ctfp_pkg::t_frame r_frame;

    // Room for a new frame when empty or when the held one leaves this cycle.
    assign o_in_ready = !r_valid || i_ready;
    assign n_valid    = i_load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_frame <= i_frame;
        end
    end

    assign o_valid = r_valid;
    assign o_frame = r_frame;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_in_ready)
        else $error("frame loaded over one still waiting");

    a_hold_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_frame)))
        else $error("waiting frame lost or changed");

endmodule

`default_nettype wire
